### design/eav_point_sharpness_unit_macros.svh
// ---------------------------------------------------------------------------
// eav point sharpness assertion macros
// shared concurrent check wrappers, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef EAV_POINT_SHARPNESS_UNIT_MACROS_SVH
`define EAV_POINT_SHARPNESS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define EPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eps check failed");
`define EPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eps check failed");
`else
`define EPS_ASSERT_IMP(lbl, ante, cons)
`define EPS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/eps_pkg.sv
// ---------------------------------------------------------------------------
// eps_pkg
// types, constants and helpers of the point sharpness focus measure
// ---------------------------------------------------------------------------
package eps_pkg;

  localparam int PIXEL_W    = 8;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 44;
  localparam int SCORE_W    = 19;
  localparam int DSUM_W     = 10;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0]   WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0]   HEIGHT_RESET = 13'd480;
  localparam logic [PIXEL_W-1:0] DIAG_WEIGHT  = 8'd179;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic interior;
    logic last;
  } flags_t;

  function automatic logic [PIXEL_W-1:0] absdiff(input logic [PIXEL_W-1:0] a,
                                                 input logic [PIXEL_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### design/eps_front.sv
// ---------------------------------------------------------------------------
// eps_front
// configuration registers, raster position tracking and beat classification
// ---------------------------------------------------------------------------
module eps_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int COL_W   = $clog2(MAX_WIDTH),
  localparam int ROW_W   = $clog2(MAX_HEIGHT),
  localparam int WD_W    = $clog2(MAX_WIDTH + 1),
  localparam int HD_W    = $clog2(MAX_HEIGHT + 1),
  localparam int AREA_W  = WD_W + HD_W,
  localparam int ENTRY_W = eps_pkg::PIXEL_W + COL_W + $bits(eps_pkg::flags_t)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [eps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eps_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [eps_pkg::PIXEL_W-1:0]   pixel,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [ENTRY_W-1:0]            q_data,
  output logic                          restart,
  output logic [AREA_W-1:0]             frame_area
);

  logic [eps_pkg::CFG_W-1:0] image_width;
  logic [eps_pkg::CFG_W-1:0] image_height;
  logic [WD_W-1:0]           w_eff;
  logic [HD_W-1:0]           h_eff;
  logic [COL_W-1:0]          col;
  logic [ROW_W-1:0]          row;
  logic                      col_last;
  logic                      row_last;
  eps_pkg::flags_t           flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= eps_pkg::WIDTH_RESET;
      image_height <= eps_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        eps_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        eps_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign restart = cfg_write && (cfg_index == eps_pkg::REG_IMAGE_WIDTH ||
                                 cfg_index == eps_pkg::REG_IMAGE_HEIGHT);

  // clamp dimensions to 3..max
  always_comb begin
    if (image_width < 13'd3) begin
      w_eff = WD_W'(3);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WD_W'(MAX_WIDTH);
    end else begin
      w_eff = WD_W'(image_width);
    end
    if (image_height < 13'd3) begin
      h_eff = HD_W'(3);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HD_W'(MAX_HEIGHT);
    end else begin
      h_eff = HD_W'(image_height);
    end
  end

  always_ff @(posedge clk) begin
    frame_area <= {{HD_W{1'b0}}, w_eff} * {{WD_W{1'b0}}, h_eff};
  end

  assign col_last = (WD_W'(col) == w_eff - WD_W'(1));
  assign row_last = (HD_W'(row) == h_eff - HD_W'(1));

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (q_push) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  always_comb begin
    flags.interior = (col >= COL_W'(2)) && (row >= ROW_W'(2));
    flags.last     = col_last && row_last;
  end

  assign q_data = {flags, col, pixel};

endmodule

### design/eps_fifo.sv
// ---------------------------------------------------------------------------
// eps_fifo
// short register queue between front and back
// ---------------------------------------------------------------------------
`include "eav_point_sharpness_unit_macros.svh"

module eps_fifo #(
  parameter int DATA_W = 22,
  parameter int DEPTH  = 4,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] head
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

  `EPS_ASSERT_IMP(a_no_overflow, push, !full)
  `EPS_ASSERT_IMP(a_no_underflow, pop, !empty)
  `EPS_ASSERT_IMP(a_empty_ptrs, empty, rd_ptr == wr_ptr)

endmodule

### design/eps_back.sv
// ---------------------------------------------------------------------------
// eps_back
// line buffers, 3x3 window, weighted differences and frame accumulator
// ---------------------------------------------------------------------------
`include "eav_point_sharpness_unit_macros.svh"

module eps_back #(
  parameter int MAX_WIDTH = 4096,
  localparam int COL_W   = $clog2(MAX_WIDTH),
  localparam int ENTRY_W = eps_pkg::PIXEL_W + COL_W + $bits(eps_pkg::flags_t)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        restart,
  input  logic                        q_empty,
  input  logic [ENTRY_W-1:0]          q_head,
  output logic                        q_pop,
  input  logic                        div_busy,
  output logic                        div_start,
  output logic [eps_pkg::SUM_W-1:0]   div_dividend
);

  localparam int PW = eps_pkg::PIXEL_W;
  localparam int DW = eps_pkg::DSUM_W;
  localparam int SW = eps_pkg::SCORE_W;
  localparam int AW = eps_pkg::SUM_W;

  eps_pkg::flags_t h_flags;
  logic [COL_W-1:0] h_col;
  logic [PW-1:0]    h_px;

  logic [PW-1:0] line_above     [MAX_WIDTH];
  logic [PW-1:0] line_two_above [MAX_WIDTH];
  logic [PW-1:0] rd_above;
  logic [PW-1:0] rd_two;

  logic            s1_valid;
  eps_pkg::flags_t s1_flags;
  logic [COL_W-1:0] s1_col;
  logic [PW-1:0]   s1_px;

  logic [PW-1:0]   win [9];
  logic            s2_valid;
  eps_pkg::flags_t s2_flags;
  logic [DW-1:0]   diag_sum;
  logic [DW-1:0]   orth_sum;

  logic            s3_valid;
  eps_pkg::flags_t s3_flags;
  logic [DW-1:0]   s3_diag;
  logic [DW-1:0]   s3_orth;
  logic [SW-2:0]   diag_prod;
  logic [SW-1:0]   term;
  logic [AW-1:0]   acc;
  logic [AW-1:0]   acc_with;

  assign {h_flags, h_col, h_px} = q_head;
  assign q_pop = !q_empty && !div_busy;

  // line buffer read on pop, written back when the popped beat reaches stage 1
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_above <= line_above[h_col];
      rd_two   <= line_two_above[h_col];
    end
    if (s1_valid) begin
      line_two_above[s1_col] <= rd_above;
      line_above[s1_col]     <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= q_pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_flags <= h_flags;
    s1_col   <= h_col;
    s1_px    <= h_px;
    s2_flags <= s1_flags;
    s3_flags <= s2_flags;
    s3_diag  <= diag_sum;
    s3_orth  <= orth_sum;
    if (s1_valid) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= rd_two;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= rd_above;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= s1_px;
    end
  end

  always_comb begin
    diag_sum = DW'(eps_pkg::absdiff(win[0], win[4])) + DW'(eps_pkg::absdiff(win[2], win[4]))
             + DW'(eps_pkg::absdiff(win[6], win[4])) + DW'(eps_pkg::absdiff(win[8], win[4]));
    orth_sum = DW'(eps_pkg::absdiff(win[1], win[4])) + DW'(eps_pkg::absdiff(win[3], win[4]))
             + DW'(eps_pkg::absdiff(win[5], win[4])) + DW'(eps_pkg::absdiff(win[7], win[4]));
  end

  assign diag_prod = {{(SW - 1 - DW){1'b0}}, s3_diag}
                   * {{(SW - 1 - PW){1'b0}}, eps_pkg::DIAG_WEIGHT};
  assign term      = {1'b0, diag_prod} + {1'b0, s3_orth, {PW{1'b0}}};
  assign acc_with  = s3_flags.interior ? acc + {{(AW - SW){1'b0}}, term} : acc;

  assign div_start    = s3_valid && s3_flags.last;
  assign div_dividend = acc_with;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      acc <= '0;
    end else if (s3_valid) begin
      acc <= s3_flags.last ? '0 : acc_with;
    end
  end

  `EPS_ASSERT_IMP(a_last_div_free, s3_valid && s3_flags.last, !div_busy)

endmodule

### design/eps_div.sv
// ---------------------------------------------------------------------------
// eps_div
// restoring divider, one quotient bit per cycle, with output register
// ---------------------------------------------------------------------------
`include "eav_point_sharpness_unit_macros.svh"

module eps_div #(
  parameter int AREA_W = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [eps_pkg::SUM_W-1:0]   dividend,
  input  logic [AREA_W-1:0]           divisor,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [eps_pkg::SCORE_W-1:0] score
);

  localparam int AW = eps_pkg::SUM_W;
  localparam int TW = eps_pkg::STEP_W;

  eps_pkg::div_state_t state;
  eps_pkg::div_state_t state_next;
  logic                load_out;

  logic [AW-1:0]     quo;
  logic [AREA_W-1:0] rem;
  logic [AREA_W-1:0] dvsr;
  logic [TW-1:0]     step;
  logic [AREA_W:0]   trial;
  logic [AREA_W:0]   diff;
  logic              ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eps_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      eps_pkg::DIV_IDLE: begin
        if (start) state_next = eps_pkg::DIV_RUN;
      end
      eps_pkg::DIV_RUN: begin
        if (step == TW'(AW - 1)) state_next = eps_pkg::DIV_DONE;
      end
      eps_pkg::DIV_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = eps_pkg::DIV_IDLE;
        end
      end
      default: state_next = eps_pkg::DIV_IDLE;
    endcase
  end

  assign busy  = (state != eps_pkg::DIV_IDLE);
  assign trial = {rem, quo[AW-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign ge    = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (start && state == eps_pkg::DIV_IDLE) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
      step <= '0;
    end else if (state == eps_pkg::DIV_RUN) begin
      quo  <= {quo[AW-2:0], ge};
      rem  <= ge ? diff[AREA_W-1:0] : trial[AREA_W-1:0];
      step <= step + TW'(1);
    end
    if (load_out) begin
      score <= quo[eps_pkg::SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `EPS_ASSERT_IMP(a_start_idle, start, state == eps_pkg::DIV_IDLE)
  `EPS_ASSERT_NXT(a_result_loaded, load_out, out_valid && state == eps_pkg::DIV_IDLE)

endmodule

### design/eav_point_sharpness_unit.sv
// ---------------------------------------------------------------------------
// eav_point_sharpness_unit
// point sharpness focus measure over a gray frame in raster order
// ---------------------------------------------------------------------------
// usage:
//   pixel beats come in on in_valid / in_stall, one 8-bit gray level each,
//   in raster order. the last beat of a frame yields one sharpness_score beat
//   on out_valid / out_stall; no other beat yields a result.
//   image_width (index 0) and image_height (index 1) are written through
//   cfg_write / cfg_index / cfg_data; any such write restarts the frame.
//   throughput: one pixel per cycle while the queue is not full and the divider
//   is idle; the line buffers take one read and one write per cycle on separate
//   addresses. after the last pixel of a frame the back end pauses while the
//   44-step shift-subtract divider runs, and the 4-deep queue takes the first
//   beats of the next frame before in_stall rises. the score of the last beat
//   comes out through the back-end stages, the divider and its output register.
//   reset: size returns to 640x480, position and accumulator clear; the line
//   buffers are not cleared, border handling never reads stale entries.
//   a stalled score is held; the next score waits in the divider, and the
//   back end then stops taking pixels until the register frees.
// ---------------------------------------------------------------------------
module eav_point_sharpness_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [eps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [eps_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [eps_pkg::PIXEL_W-1:0]   pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [eps_pkg::SCORE_W-1:0]   sharpness_score
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int AREA_W  = $clog2(MAX_WIDTH + 1) + $clog2(MAX_HEIGHT + 1);
  localparam int ENTRY_W = eps_pkg::PIXEL_W + COL_W + $bits(eps_pkg::flags_t);

  logic                      q_push;
  logic [ENTRY_W-1:0]        q_data;
  logic                      q_full;
  logic                      q_pop;
  logic                      q_empty;
  logic [ENTRY_W-1:0]        q_head;
  logic                      restart;
  logic [AREA_W-1:0]         frame_area;
  logic                      div_busy;
  logic                      div_start;
  logic [eps_pkg::SUM_W-1:0] div_dividend;

  eps_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel      (pixel),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data),
    .restart    (restart),
    .frame_area (frame_area)
  );

  eps_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (eps_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  eps_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .div_busy     (div_busy),
    .div_start    (div_start),
    .div_dividend (div_dividend)
  );

  eps_div #(
    .AREA_W (AREA_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (frame_area),
    .busy      (div_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .score     (sharpness_score)
  );

endmodule
